// ----- hw/rtl/iiws_pkg.sv -----
// Shared types, constants and a helper for the integral image block.
package iiws_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register width and reset values.
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(MAX_HEIGHT);

    // Accumulator widths.
    localparam int PIX_W       = 8;
    localparam int PIX_SQ_W    = 2 * PIX_W;
    localparam int COL_SUM_W   = 18;
    localparam int COL_SQ_W    = 26;
    localparam int ROW_SUM_W   = 29;
    localparam int ROW_SQ_W    = 36;
    localparam int OUT_SUM_W   = 28;
    localparam int OUT_SQ_W    = 36;
    localparam int OUT_DATA_W  = OUT_SUM_W + OUT_SQ_W;

    // Configuration register indexes, as decoded from the word address.
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } iiws_reg_t;

    // Position flags that follow each pixel down the pipeline.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } iiws_tag_t;

    // One entry of the column memory.
    typedef struct packed {
        logic [COL_SQ_W-1:0]  sq;
        logic [COL_SUM_W-1:0] sum;
    } iiws_col_t;

    // Maps a programmed size to the size in use: zero acts as one, large values saturate.
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > limit) begin
            r = limit;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/iiws_pos_ctrl.sv -----
// Raster position counters that tag each pixel with its column and frame edges.
module iiws_pos_ctrl
    import iiws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_clear,
    input  logic             in_accept,
    input  logic [CFG_W-1:0] frame_width,
    input  logic [CFG_W-1:0] frame_height,
    output logic [COL_W-1:0] col,
    output iiws_tag_t        tag
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [ROW_W-1:0] row;
    logic             last_col, last_row;

    assign w_eff = eff_size(frame_width, WIDTH_LIMIT);
    assign h_eff = eff_size(frame_height, HEIGHT_LIMIT);

    // Guard the counters against a position beyond the frame in use.
    assign col = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign row = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;

    assign last_col = ({1'b0, col} == (w_eff - CFG_W'(1)));
    assign last_row = ({1'b0, row} == (h_eff - CFG_W'(1)));

    assign tag.first_row = (row == '0);
    assign tag.first_col = (col == '0);
    assign tag.last      = last_col && last_row;

    // Advance in raster order, wrapping at the frame size.
    always_comb begin
        col_next = col + COL_W'(1);
        row_next = row;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- hw/rtl/iiws_col_acc.sv -----
// Column memory with read-modify-write of the per-column sums and sums of squares.
module iiws_col_acc
    import iiws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] pixel,
    input  logic [COL_W-1:0] col,
    input  iiws_tag_t        tag,
    output logic             col_valid,
    output iiws_col_t        col_data,
    output iiws_tag_t        col_tag
);

    // Column memory, one entry per column, registered read.
    iiws_col_t mem [MAX_WIDTH];

    // Read stage: pixel waiting for its column entry.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    iiws_tag_t        s1_tag_reg;
    iiws_col_t        rd_data_reg;
    logic             fwd_reg;
    iiws_col_t        fwd_data_reg;

    // Update stage output.
    logic      s2_valid_reg;
    iiws_col_t s2_data_reg;
    iiws_tag_t s2_tag_reg;

    logic [PIX_SQ_W-1:0] pix_sq;
    iiws_col_t           base;
    iiws_col_t           upd;

    // Square of the pixel and the updated column entry; the first row restarts it.
    assign pix_sq = PIX_SQ_W'(s1_pixel_reg) * PIX_SQ_W'(s1_pixel_reg);
    assign base   = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb begin
        if (s1_tag_reg.first_row) begin
            upd.sum = COL_SUM_W'(s1_pixel_reg);
            upd.sq  = COL_SQ_W'(pix_sq);
        end else begin
            upd.sum = base.sum + COL_SUM_W'(s1_pixel_reg);
            upd.sq  = base.sq + COL_SQ_W'(pix_sq);
        end
    end

    // Memory write-back and read; the read returns the old entry when both hit one column.
    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            mem[s1_col_reg] <= upd;
        end
        if (advance && in_valid) begin
            rd_data_reg <= mem[col];
        end
    end

    // Forward a write-back to a read of the same column in the same cycle.
    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            fwd_data_reg <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (advance && in_valid) begin
            fwd_reg <= s1_valid_reg && (s1_col_reg == col);
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col;
            s1_tag_reg   <= tag;
            s2_data_reg  <= upd;
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign col_valid = s2_valid_reg;
    assign col_data  = s2_data_reg;
    assign col_tag   = s2_tag_reg;

endmodule

// ----- hw/rtl/iiws_row_acc.sv -----
// Running sums along the row and the output register of the result channel.
module iiws_row_acc
    import iiws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  col_valid,
    input  iiws_col_t             col_data,
    input  iiws_tag_t             col_tag,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    logic [ROW_SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [ROW_SQ_W-1:0]  row_sq_reg, row_sq_next;
    logic                 out_valid_reg;
    logic [OUT_SUM_W-1:0] out_sum_reg;
    logic [OUT_SQ_W-1:0]  out_sq_reg;
    logic                 out_last_reg;

    // Add the column totals along the row; the first column restarts the row.
    always_comb begin
        if (col_tag.first_col) begin
            row_sum_next = ROW_SUM_W'(col_data.sum);
            row_sq_next  = ROW_SQ_W'(col_data.sq);
        end else begin
            row_sum_next = row_sum_reg + ROW_SUM_W'(col_data.sum);
            row_sq_next  = row_sq_reg + ROW_SQ_W'(col_data.sq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg   <= '0;
            row_sq_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= col_valid;
            if (col_valid) begin
                row_sum_reg <= row_sum_next;
                row_sq_reg  <= row_sq_next;
            end
        end
    end

    // Result payload, held while the downstream side stalls.
    always_ff @(posedge aclk) begin
        if (advance && col_valid) begin
            out_sum_reg  <= OUT_SUM_W'(row_sum_next);
            out_sq_reg   <= OUT_SQ_W'(row_sq_next);
            out_last_reg <= col_tag.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_sq_reg, out_sum_reg};
    assign out_last  = out_last_reg;

endmodule

// ----- hw/rtl/integral_image_with_squares.sv -----
// Top level of the integral image block with squared sums and its register port.
//
// The block takes one 8-bit pixel per clock in raster order while the output is not
// stalled and returns, for each pixel, the sum and the sum of squares of all pixels above
// and to the left of it, itself included, with tlast on the last pixel of the frame. A
// pixel passes the read stage, the update stage and the output register in turn. The rate
// is set by the column memory (1024 entries of sum and sum of squares), which is read once
// and written once per pixel; a write-back that meets a read of the same column is
// forwarded. Row 0 of each frame overwrites every column, so the memory needs no clearing
// after reset. Writing either size register restarts the frame at the top-left pixel;
// the user must write registers only while no pixel is in flight; the block does not
// enforce this. A size of zero acts as one, and sizes above 1024 act as 1024.
module integral_image_with_squares
    import iiws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Pixel requests.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_value
    // Result requests.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [27:0] integral_sum, [63:28] integral_square_sum
    output logic                  m_tlast    // end_of_frame
);

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_write;
    iiws_reg_t        reg_sel;
    logic             advance;
    logic             in_accept;
    logic [COL_W-1:0] col;
    iiws_tag_t        tag;
    logic             col_valid;
    iiws_col_t        col_data;
    iiws_tag_t        col_tag;

    // Register decode and write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = iiws_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_LIMIT;
            frame_height_reg <= HEIGHT_LIMIT;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // The whole pipeline moves whenever the output register is free or being taken.
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign in_accept = s_tvalid && s_tready;

    iiws_pos_ctrl u_pos_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_clear    (cfg_write),
        .in_accept    (in_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .tag          (tag)
    );

    iiws_col_acc u_col_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (in_accept),
        .pixel     (s_tdata),
        .col       (col),
        .tag       (tag),
        .col_valid (col_valid),
        .col_data  (col_data),
        .col_tag   (col_tag)
    );

    iiws_row_acc u_row_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .col_valid (col_valid),
        .col_data  (col_data),
        .col_tag   (col_tag),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
